FILE: design/rtd_pkg.sv
// Shared types, constants and lookup tables for the RTD sample-to-temperature unit.
// Depends on nothing; every other design file imports it.
package rtd_pkg;

   localparam int AVERAGE_DEPTH_DEFAULT = 25;

   localparam int ADC_W    = 12;
   localparam int OFFSET_W = 18;
   localparam int VOLT_W   = 20;
   localparam int TEMP_W   = 17;
   localparam int SMOOTH_W = 18;

   // Volts scaling: raw * 216269 / 4095 in Q16, as a reciprocal multiply and shift,
   // exact for every 12-bit raw value
   localparam int SCALE_MUL   = 886054146;
   localparam int SCALE_SHIFT = 24;
   localparam int PROD_W      = 42;
   localparam int ACC_W       = 22;
   // Smoother: acc / 10 as a reciprocal multiply and shift, exact below 2^26
   localparam int SMOOTH_MUL    = 13421773;
   localparam int SMOOTH_SHIFT  = 27;
   localparam int SMOOTH_PROD_W = 46;
   localparam int NUM_W  = 27;

   // Shared divider
   localparam int DIV_W     = 32;
   localparam int DIVISOR_W = 14;
   localparam int DIV_STEPS = 4;

   localparam logic DIV_AVG    = 1'b0;
   localparam logic DIV_INTERP = 1'b1;

   // Interpolation table
   localparam int TABLE_POINTS = 10;
   localparam int SEG_COUNT    = TABLE_POINTS - 1;
   localparam int SEG_W        = $clog2(SEG_COUNT);
   localparam int DT_W         = 13;
   localparam int DV_W         = 14;

   localparam logic signed [VOLT_W-1:0] VOLT_Q16 [TABLE_POINTS] = '{
      20'sd2097, 20'sd16384, 20'sd30147, 20'sd43254, 20'sd57016,
      20'sd69468, 20'sd81920, 20'sd94372, 20'sd106168, 20'sd117965
   };
   localparam logic signed [TEMP_W-1:0] TEMP_CDEG [TABLE_POINTS] = '{
      -17'sd5000, 17'sd0, 17'sd5000, 17'sd10000, 17'sd15000,
      17'sd20000, 17'sd25000, 17'sd30000, 17'sd35000, 17'sd40000
   };
   localparam logic [DT_W-1:0] SEG_DT [SEG_COUNT] = '{
      13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000,
      13'd5000, 13'd5000, 13'd5000, 13'd5000
   };
   localparam logic [DV_W-1:0] SEG_DV [SEG_COUNT] = '{
      14'd14287, 14'd13763, 14'd13107, 14'd13762, 14'd12452,
      14'd12452, 14'd12452, 14'd11796, 14'd11797
   };

   typedef struct packed {
      logic       cap_in;
      logic       mul;
      logic       div_start;
      logic       div_sel;
      logic       acc_upd;
      logic       smooth_upd;
      logic       ring_upd;
      logic       avg_upd;
      logic       seg_upd;
      logic       num_upd;
      logic       temp_upd;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic clamp;
   } status_type;

endpackage

FILE: design/rtd_req_if.sv
// Request channel interface: one raw converter sample per transfer.
// Depends on rtd_pkg for field widths.
interface rtd_req_if;
   import rtd_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

FILE: design/rtd_rsp_if.sv
// Response channel interface: filtered voltage and temperature per transfer.
// Depends on rtd_pkg for field widths.
interface rtd_rsp_if;
   import rtd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [VOLT_W-1:0] filtered_voltage;
   logic signed [TEMP_W-1:0] temperature;
   modport source (output valid, output filtered_voltage, output temperature, input ready);
   modport sink (input valid, input filtered_voltage, input temperature, output ready);
endinterface

FILE: design/rtd_div.sv
// Shared iterative divider, four quotient bits per cycle, optional negated result.
// Depends on rtd_pkg.
module rtd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rtd_pkg::DIV_W-1:0]        dividend,
   input  logic [rtd_pkg::DIVISOR_W-1:0]    divisor,
   input  logic                             negate,
   output logic                             done,
   output logic [rtd_pkg::DIV_W-1:0]        quotient
);
   import rtd_pkg::*;

   localparam int DIV_ITER = DIV_W / DIV_STEPS;
   localparam int IT_W     = $clog2(DIV_ITER);

   logic [DIV_W-1:0]     dq_ff, dq_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] d_ff;
   logic                 neg_ff;
   logic [IT_W-1:0]      it_ff;
   logic                 busy_ff, done_ff;

   always_comb begin
      logic [DIVISOR_W:0] t;
      rem_in = rem_ff;
      dq_in  = dq_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         t     = {rem_in, dq_in[DIV_W-1]};
         dq_in = {dq_in[DIV_W-2:0], 1'b0};
         if (t >= {1'b0, d_ff}) begin
            rem_in   = DIVISOR_W'(t - {1'b0, d_ff});
            dq_in[0] = 1'b1;
         end else begin
            rem_in = t[DIVISOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
         neg_ff <= negate;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            it_ff   <= '0;
         end else if (busy_ff) begin
            it_ff <= it_ff + 1'b1;
            if (it_ff == IT_W'(DIV_ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~dq_ff + 1'b1) : dq_ff;

endmodule

FILE: design/rtd_datapath.sv
// Datapath: scaling, smoother, moving-average ring and table interpolation.
// Depends on rtd_pkg and rtd_div; steered by rtd_ctrl through cmd_type.
module rtd_datapath #(
   parameter int AVERAGE_DEPTH = rtd_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rtd_pkg::cmd_type                    cmd,
   output rtd_pkg::status_type                 status,
   input  logic [rtd_pkg::ADC_W-1:0]           adc_sample,
   input  logic                                csr_write_enable,
   input  logic [rtd_pkg::OFFSET_W-1:0]        csr_write_data,
   output logic signed [rtd_pkg::VOLT_W-1:0]   filtered_voltage,
   output logic signed [rtd_pkg::TEMP_W-1:0]   temperature
);
   import rtd_pkg::*;

   localparam int WP_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int CNT_W = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W = VOLT_W + $clog2(AVERAGE_DEPTH);

   logic [OFFSET_W-1:0]        offset_ff;
   logic [ADC_W-1:0]           raw_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [SMOOTH_PROD_W-1:0]   smooth_prod;
   logic [SMOOTH_W-1:0]        smooth_ff;
   logic signed [VOLT_W-1:0]   ring_ff [AVERAGE_DEPTH];
   logic signed [VOLT_W-1:0]   old_ff;
   logic signed [VOLT_W-1:0]   entry;
   logic [WP_W-1:0]            wpos_ff, wpos_in;
   logic                       full_ff, full_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           sum_mag;
   logic signed [VOLT_W-1:0]   avg_ff;
   logic [SEG_W-1:0]           seg_ff, seg_in;
   logic                       clamp_ff, hi_ff;
   logic                       lo_in, hi_in;
   logic signed [VOLT_W-1:0]   diff;
   logic [NUM_W-1:0]           num_ff;
   logic signed [TEMP_W-1:0]   temp_ff, temp_in;
   logic signed [VOLT_W-1:0]   fv_ff;
   logic signed [TEMP_W-1:0]   ft_ff;

   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_negate;
   logic                 div_done;
   logic [DIV_W-1:0]     div_q;

   rtd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .negate   (div_negate),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      div_negate = 1'b0;
      case (cmd.div_sel)
         DIV_AVG: begin
            div_dividend = DIV_W'(sum_mag);
            div_divisor  = DIVISOR_W'(cnt_ff);
            div_negate   = sum_ff[SUM_W-1];
         end
         DIV_INTERP: begin
            div_dividend = DIV_W'(num_ff);
            div_divisor  = SEG_DV[seg_ff];
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DIVISOR_W'(1);
         end
      endcase
   end

   // Smoother accumulator: 9 * old + scaled sample
   assign acc_in = ({4'b0, smooth_ff} << 3) + {4'b0, smooth_ff}
                 + ACC_W'(prod_ff[SCALE_SHIFT +: SMOOTH_W]);

   assign smooth_prod = SMOOTH_PROD_W'(acc_ff) * SMOOTH_PROD_W'(SMOOTH_MUL);

   assign entry = $signed({2'b00, smooth_ff})
                + $signed({{(VOLT_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff});

   always_comb begin
      if (wpos_ff == WP_W'(AVERAGE_DEPTH - 1)) begin
         wpos_in = '0;
         full_in = 1'b1;
      end else begin
         wpos_in = wpos_ff + 1'b1;
         full_in = full_ff;
      end
      cnt_in = full_in ? CNT_W'(AVERAGE_DEPTH) : CNT_W'(wpos_ff) + 1'b1;
      // Drop the overwritten entry only once the ring has wrapped
      sum_in = sum_ff + SUM_W'(entry) - (full_ff ? SUM_W'(old_ff) : SUM_W'(0));
   end

   always_comb begin
      lo_in  = (avg_ff <= VOLT_Q16[0]);
      hi_in  = (avg_ff >= VOLT_Q16[TABLE_POINTS-1]);
      seg_in = SEG_W'(SEG_COUNT - 1);
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (avg_ff <= VOLT_Q16[i+1]) seg_in = SEG_W'(i);
      end
   end

   assign diff = avg_ff - VOLT_Q16[seg_ff];

   always_comb begin
      if (clamp_ff) begin
         temp_in = hi_ff ? TEMP_CDEG[TABLE_POINTS-1] : TEMP_CDEG[0];
      end else begin
         temp_in = TEMP_CDEG[seg_ff] + $signed({4'b0, div_q[DT_W-1:0]});
      end
   end

   // Ring memory, registered read at the current write position
   always_ff @(posedge clock) begin
      if (cmd.ring_upd) ring_ff[wpos_ff] <= entry;
      old_ff <= ring_ff[wpos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_in)   raw_ff  <= adc_sample;
      if (cmd.mul)      prod_ff <= PROD_W'(raw_ff) * PROD_W'(SCALE_MUL);
      if (cmd.acc_upd)  acc_ff  <= acc_in;
      if (cmd.ring_upd) cnt_ff  <= cnt_in;
      if (cmd.avg_upd)  avg_ff  <= div_q[VOLT_W-1:0];
      if (cmd.seg_upd) begin
         seg_ff   <= seg_in;
         clamp_ff <= lo_in | hi_in;
         hi_ff    <= hi_in;
      end
      if (cmd.num_upd) begin
         num_ff <= NUM_W'(SEG_DT[seg_ff]) * NUM_W'(diff[DV_W-1:0]);
         if (clamp_ff) temp_ff <= temp_in;
      end
      if (cmd.temp_upd) temp_ff <= temp_in;
      if (cmd.out_load) begin
         fv_ff <= avg_ff;
         ft_ff <= temp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         smooth_ff <= '0;
         wpos_ff   <= '0;
         full_ff   <= 1'b0;
         sum_ff    <= '0;
      end else begin
         if (csr_write_enable) offset_ff <= csr_write_data;
         if (cmd.smooth_upd)   smooth_ff <= smooth_prod[SMOOTH_SHIFT +: SMOOTH_W];
         if (cmd.ring_upd) begin
            wpos_ff <= wpos_in;
            full_ff <= full_in;
            sum_ff  <= sum_in;
         end
      end
   end

   assign status.div_done = div_done;
   assign status.clamp    = clamp_ff;

   assign filtered_voltage = fv_ff;
   assign temperature      = ft_ff;

   a_wpos_range: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= WP_W'(AVERAGE_DEPTH - 1))
      else $error("ring write position past the last entry");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("ring full flag cleared without reset");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      cmd.temp_upd |=> (temp_ff >= TEMP_CDEG[0] && temp_ff <= TEMP_CDEG[TABLE_POINTS-1]))
      else $error("interpolated temperature outside table range");

endmodule

FILE: design/rtd_ctrl.sv
// Controller state machine: sequences one sample through the datapath and
// owns the channel handshakes. Depends on rtd_pkg.
module rtd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtd_pkg::cmd_type     cmd,
   input  rtd_pkg::status_type  status
);
   import rtd_pkg::*;

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_MUL         = 4'd1;
   localparam logic [3:0] S_SCALE       = 4'd2;
   localparam logic [3:0] S_SMOOTH      = 4'd3;
   localparam logic [3:0] S_ENTRY       = 4'd4;
   localparam logic [3:0] S_AVG_GO      = 4'd5;
   localparam logic [3:0] S_AVG_WAIT    = 4'd6;
   localparam logic [3:0] S_SEG         = 4'd7;
   localparam logic [3:0] S_NUM         = 4'd8;
   localparam logic [3:0] S_INTERP_GO   = 4'd9;
   localparam logic [3:0] S_INTERP_WAIT = 4'd10;
   localparam logic [3:0] S_OUT         = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_in = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.acc_upd = 1'b1;
            state_in    = S_SMOOTH;
         end
         S_SMOOTH: begin
            cmd.smooth_upd = 1'b1;
            state_in       = S_ENTRY;
         end
         S_ENTRY: begin
            cmd.ring_upd = 1'b1;
            state_in     = S_AVG_GO;
         end
         S_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_AVG;
            state_in      = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.avg_upd = 1'b1;
               state_in    = S_SEG;
            end
         end
         S_SEG: begin
            cmd.seg_upd = 1'b1;
            state_in    = S_NUM;
         end
         S_NUM: begin
            // Clamped averages already have their temperature
            cmd.num_upd = 1'b1;
            state_in    = status.clamp ? S_OUT : S_INTERP_GO;
         end
         S_INTERP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_INTERP;
            state_in      = S_INTERP_WAIT;
         end
         S_INTERP_WAIT: begin
            if (status.div_done) begin
               cmd.temp_upd = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_AVG_WAIT || state_ff == S_INTERP_WAIT))
      else $error("divider finished outside a wait state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_MUL)
      else $error("accepted sample did not start processing");

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid && state_ff == S_IDLE))
      else $error("result load did not present a response");

endmodule

FILE: design/rtd_sample_to_temperature_unit.sv
// Top level of the RTD sample-to-temperature unit.
// Depends on rtd_pkg, rtd_req_if, rtd_rsp_if, rtd_ctrl and rtd_datapath.
//
// Usage:
//   req_chan carries one 12-bit converter sample per transfer. rsp_chan returns,
//   for every sample, the moving-average voltage (signed Q16) and the
//   interpolated temperature in hundredths of a degree Celsius.
//   csr_write_enable/csr_write_data load the signed Q16 voltage offset; write it
//   only while no sample is in flight.
// Sequencing:
//   One sample at a time, through scaling, smoothing, the ring update, the
//   averaging divide, the segment search and the interpolation divide, then
//   rsp_chan.valid rises; an average at or beyond a table end skips the
//   interpolation divide. req_chan.ready is high only while the sequencer is
//   idle. Scaling and smoothing are multiplies; the average and the
//   interpolation share the divider (four quotient bits per cycle).
// Reset:
//   Synchronous, active high. Clears the offset, smoother, ring position,
//   fill state and running sum; no response is pending after reset.
// Backpressure:
//   A finished response waits in the output register; the next sample is
//   accepted and processed meanwhile, and its result waits until the
//   previous response has been transferred.
module rtd_sample_to_temperature_unit #(
   parameter int AVERAGE_DEPTH = rtd_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   rtd_req_if.sink                         req_chan,
   rtd_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [rtd_pkg::OFFSET_W-1:0]    csr_write_data
);
   import rtd_pkg::*;

   cmd_type    cmd;
   status_type status;

   rtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rtd_datapath #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .adc_sample       (req_chan.adc_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .filtered_voltage (rsp_chan.filtered_voltage),
      .temperature      (rsp_chan.temperature)
   );

endmodule

FILE: tb/sv/rtd_temperature_check.sv
// Predicts and checks every response of the RTD sample-to-temperature unit.
// It watches the request, response and offset ports and computes the expected reading.
// Depends on rtd_pkg, rtd_req_if and rtd_rsp_if.
module rtd_temperature_check #(
   parameter int RING_DEPTH = rtd_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   rtd_req_if                           req_chan,
   rtd_rsp_if                           rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [rtd_pkg::OFFSET_W-1:0] csr_write_data,
   input  logic                         drain,
   output int                           mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rtd_pkg::*;

   localparam int KNEES = 10;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic signed [VOLT_W-1:0] filtered_voltage;
      logic signed [TEMP_W-1:0] temperature;
   } reading_type;

   int knee_volt [KNEES] = '{2097, 16384, 30147, 43254, 57016,
                             69468, 81920, 94372, 106168, 117965};
   int knee_temp [KNEES] = '{-5000, 0, 5000, 10000, 15000,
                             20000, 25000, 30000, 35000, 40000};

   reading_type expected_readings [$];
   longint   offset_q16;
   longint   smooth_q16;
   longint   ring_entry [RING_DEPTH];
   longint   ring_total;
   int       ring_slot;
   bit       ring_filled;
   bit       drained;
   int       checked_count;
   int       below_count;
   int       above_count;
   int       negative_count;
   int       offset_writes;

   function automatic longint temp_for_volts(longint volts);
      longint result;
      result = knee_temp[KNEES-1];
      if (volts <= knee_volt[0]) begin
         result = knee_temp[0];
      end else if (volts < knee_volt[KNEES-1]) begin
         // walk down so the lowest matching segment wins on a shared knee
         for (int k = KNEES - 2; k >= 0; k--) begin
            if (volts >= knee_volt[k] && volts <= knee_volt[k+1]) begin
               result = knee_temp[k] + (knee_temp[k+1] - knee_temp[k]) *
                        (volts - knee_volt[k]) / (knee_volt[k+1] - knee_volt[k]);
            end
         end
      end
      return result;
   endfunction

   task automatic predict_reading(logic [ADC_W-1:0] raw);
      longint   volts;
      longint   entry;
      longint   fill;
      longint   average;
      longint   temp;
      reading_type want;
      volts = longint'(raw) * 216269 / 4095;
      smooth_q16 = (9 * smooth_q16 + volts) / 10;
      entry = smooth_q16 + offset_q16;
      if (ring_filled) ring_total -= ring_entry[ring_slot];
      ring_entry[ring_slot] = entry;
      ring_total += entry;
      ring_slot++;
      if (ring_slot == RING_DEPTH) begin
         ring_slot = 0;
         ring_filled = 1'b1;
      end
      fill = ring_filled ? RING_DEPTH : ring_slot;
      average = ring_total / fill;
      temp = temp_for_volts(average);
      if (average <= knee_volt[0]) below_count++;
      if (average >= knee_volt[KNEES-1]) above_count++;
      if (average < 0) negative_count++;
      want.filtered_voltage = average[VOLT_W-1:0];
      want.temperature = temp[TEMP_W-1:0];
      expected_readings.push_back(want);
   endtask

   task automatic report_mismatch(string what, string got, string want);
      if (mismatch_count < PRINT_CAP)
         $display("tb: mismatch at response %0d: %s, got %s, expected %s",
                  checked_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_reading();
      reading_type want;
      if (expected_readings.size() == 0) begin
         report_mismatch("response with nothing pending", "transfer", "none");
      end else begin
         want = expected_readings.pop_front();
         if (rsp_chan.filtered_voltage !== want.filtered_voltage)
            report_mismatch("filtered_voltage",
                            $sformatf("%0d", rsp_chan.filtered_voltage),
                            $sformatf("%0d", want.filtered_voltage));
         if (rsp_chan.temperature !== want.temperature)
            report_mismatch("temperature",
                            $sformatf("%0d", rsp_chan.temperature),
                            $sformatf("%0d", want.temperature));
      end
      checked_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_readings.delete();
         offset_q16 = 0;
         smooth_q16 = 0;
         ring_total = 0;
         ring_slot = 0;
         ring_filled = 1'b0;
      end else begin
         if (csr_write_enable === 1'b1) begin
            offset_q16 = longint'($signed(csr_write_data));
            offset_writes++;
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            predict_reading(req_chan.adc_sample);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            check_reading();
         if (drain && !drained) begin
            drained = 1'b1;
            if (expected_readings.size() != 0)
               report_mismatch("readings never returned",
                               "0", $sformatf("%0d", expected_readings.size()));
            $display("tb: %0d readings over %0d offset writes:",
                     checked_count, offset_writes);
            $display("tb: %0d below table, %0d above, %0d negative averages",
                     below_count, above_count, negative_count);
         end
      end
   end

endmodule

FILE: tb/sv/tb.sv
// Top of the RTD sample-to-temperature testbench: clock, reset, stimulus and verdict.
// Drives samples and offset writes; rtd_temperature_check does the predicting.
// Depends on rtd_pkg, rtd_req_if, rtd_rsp_if, rtd_temperature_check and the unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rtd_pkg::*;

   localparam int RING_DEPTH = AVERAGE_DEPTH_DEFAULT;
   localparam int PHASES = 6;
   localparam int PER_PHASE = 122;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 60;

   typedef enum int {RUN_HOLD, RUN_NOISE, RUN_RAIL, RUN_RAMP} run_kind_type;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [OFFSET_W-1:0] csr_write_data;
   logic                drain;
   int                  mismatch_count;
   int                  sent_count;
   int                  got_count;
   int                  cycle_count;

   logic [ADC_W-1:0] opening [14] = '{12'd0, 12'd4095, 12'd0, 12'd1, 12'd2048, 12'd4094,
                                      12'hAAA, 12'h555, 12'd2047, 12'd4095, 12'd4095,
                                      12'd4095, 12'd4095, 12'd4095};

   rtd_req_if req_chan ();
   rtd_rsp_if rsp_chan ();

   rtd_sample_to_temperature_unit #(.AVERAGE_DEPTH(RING_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rtd_temperature_check #(.RING_DEPTH(RING_DEPTH)) temp_check (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .drain            (drain),
      .mismatch_count   (mismatch_count)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         got_count <= got_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: run timed out after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stall before each transfer, with calm stretches
   initial begin : response_sink
      int stall;
      bit calm;
      rsp_chan.ready = 1'b0;
      calm = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         @(negedge clock);
      end
   end

   task automatic send_sample(logic [ADC_W-1:0] value, bit steady);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.adc_sample <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent_count++;
      @(negedge clock);
   endtask

   // drop valid and wait until every sample has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (got_count != sent_count) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_offset(logic [OFFSET_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // one run of related samples: plateaus let the smoother and average settle
   task automatic send_run(input int room, output int issued);
      run_kind_type     kind;
      int               len;
      int               stride;
      bit               steady;
      logic [ADC_W-1:0] level;
      logic [ADC_W-1:0] value;
      kind = run_kind_type'($urandom_range(0, 3));
      len = $urandom_range(1, 40);
      if (len > room) len = room;
      stride = $urandom_range(1, 200);
      if ($urandom_range(0, 1) == 0) stride = -stride;
      steady = ($urandom_range(0, 3) == 0);
      level = ADC_W'($urandom);
      for (int k = 0; k < len; k++) begin
         case (kind)
            RUN_HOLD:  value = level;
            RUN_NOISE: value = ADC_W'($urandom);
            RUN_RAIL:  value = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            default: begin
               value = level;
               level = ADC_W'(int'(level) + stride);
            end
         endcase
         send_sample(value, steady);
      end
      issued = len;
   endtask

   initial begin : stimulus
      logic [OFFSET_W-1:0] offset;
      int                  issued;
      int                  run_len;
      reset = 1'b1;
      drain = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.adc_sample = '0;
      sent_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero offset from reset: rails, midscale and alternating bit patterns
      foreach (opening[k]) send_sample(opening[k], 1'b0);
      settle();
      // most negative offset with a low input drives the new ring entries below zero
      write_offset(18'h20000);
      repeat (3) send_sample(12'd0, 1'b0);
      settle();
      write_offset(18'h1FFFF);
      repeat (5) send_sample(12'hFFF, 1'b0);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1:       offset = '0;
            2:       offset = 18'h10000;
            3:       offset = 18'h30000;
            4:       offset = OFFSET_W'($urandom);
            default: offset = OFFSET_W'($urandom_range(0, 131072) - 65536);
         endcase
         write_offset(offset);
         issued = 0;
         while (issued < PER_PHASE) begin
            send_run(PER_PHASE - issued, run_len);
            issued += run_len;
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      drain <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
